FILE: src/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

  localparam int unsigned ENTRIES_DEF  = 8;
  localparam int unsigned KEY_BITS_DEF = 32;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CAP_W   = 4;

  localparam logic [CAP_W-1:0]          CAP_RESET  = 4'd8;
  localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } opcode_e;

  // Status of one lookup sweep.
  typedef struct packed {
    logic match;
    logic lru;
    logic free;
  } scan_flags_t;

endpackage

FILE: src/lkv_req_if.sv
// Request channel: get or put on a key.
interface lkv_req_if import lkv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [0:0]                opcode;
  logic [KEY_W-1:0]          key;
  logic signed [VALUE_W-1:0] put_value;

  modport source (output valid, opcode, key, put_value, input ready);
  modport sink   (input valid, opcode, key, put_value, output ready);
endinterface

FILE: src/lkv_rsp_if.sv
// Response channel: one result per request.
interface lkv_rsp_if import lkv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [VALUE_W-1:0] read_value;
  logic                      evicted;
  logic [KEY_W-1:0]          evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

FILE: src/lkv_cfg_if.sv
// Configuration write channel for the capacity register.
interface lkv_cfg_if import lkv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

FILE: src/lkv_ram.sv
// Generic simple dual-port RAM with registered read.
module lkv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/lkv_scan.sv
// Compare unit: checks one entry per cycle while strobe_i is high, for key match, LRU and free slot.
module lkv_scan import lkv_pkg::*; #(
  parameter int unsigned ENTRIES  = ENTRIES_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      strobe_i,
  input  logic [IW-1:0]             idx_i,
  input  logic                      entry_valid_i,
  input  logic [KW-1:0]             entry_key_i,
  input  logic [IW-1:0]             entry_rank_i,
  input  logic signed [VALUE_W-1:0] entry_value_i,
  input  logic [KW-1:0]             lookup_key_i,
  output scan_flags_t               flags_o,
  output logic [IW-1:0]             match_idx_o,
  output logic [IW-1:0]             match_rank_o,
  output logic signed [VALUE_W-1:0] match_value_o,
  output logic [IW-1:0]             lru_idx_o,
  output logic [KW-1:0]             lru_key_o,
  output logic [IW-1:0]             free_idx_o
);

  scan_flags_t flags_q;
  logic [IW-1:0] lru_rank_q;
  logic take_match, take_lru, take_free;

  assign take_match = strobe_i && entry_valid_i && !flags_q.match
                      && (entry_key_i == lookup_key_i);
  assign take_lru   = strobe_i && entry_valid_i
                      && (!flags_q.lru || entry_rank_i > lru_rank_q);
  assign take_free  = strobe_i && !entry_valid_i && !flags_q.free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (clear_i) begin
      flags_q <= '0;
    end else begin
      if (take_match) flags_q.match <= 1'b1;
      if (take_lru)   flags_q.lru   <= 1'b1;
      if (take_free)  flags_q.free  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_match) begin
      match_idx_o   <= idx_i;
      match_rank_o  <= entry_rank_i;
      match_value_o <= entry_value_i;
    end
    if (take_lru) begin
      lru_idx_o  <= idx_i;
      lru_rank_q <= entry_rank_i;
      lru_key_o  <= entry_key_i;
    end
    if (take_free) begin
      free_idx_o <= idx_i;
    end
  end

  assign flags_o = flags_q;

endmodule

FILE: src/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
//
// Channels: req_i carries opcode (get/put), key and put_value; rsp_o returns
// hit, read_value, evicted and evicted_key, one response per request; cfg_i
// writes capacity_in_use and is always ready (write it only while idle).
// All three use valid/ready; a transfer happens when both are high.
//
// Each request is handled by a sequencer around one compare unit and one
// entry RAM: a lookup sweep reads all ENTRIES entries one per cycle, then,
// for a hit or a put, an update sweep rewrites the recency ranks one entry
// per cycle. req_i.ready returns high together with the response in the
// output register, so the single RAM port pair and the per-entry sweeps
// keep one request in flight at a time.
//
// The response sits in an output register; a new request is taken while it
// waits, and the next response waits until rsp_o.ready.
// Reset empties the cache (valid bits and occupancy cleared) and sets the
// capacity to 8; entry RAM contents need no clearing.
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int unsigned ENTRIES  = ENTRIES_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lkv_req_if.sink   req_i,
  lkv_rsp_if.source rsp_o,
  lkv_cfg_if.sink   cfg_i
);

  localparam int unsigned IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned OW    = $clog2(ENTRIES + 1);
  localparam int unsigned CW    = (OW > CAP_W) ? OW : CAP_W;
  localparam int unsigned ROW_W = KW + VALUE_W + IW;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_END, ST_DECIDE, ST_UPD, ST_UPD_END, ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d, ridx_q, ridx_d, tgt_q, tgt_d, rank_q, rank_d;
  logic rvld_q, rvld_d, ins_q, ins_d;
  opcode_e op_q, op_d;
  logic [KW-1:0] key_q, key_d;
  logic signed [VALUE_W-1:0] val_q, val_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [OW-1:0] occ_q, occ_d;

  logic res_hit_q, res_hit_d, res_ev_q, res_ev_d;
  logic signed [VALUE_W-1:0] res_val_q, res_val_d;
  logic [KEY_W-1:0] res_evk_q, res_evk_d;
  logic out_valid_q, out_valid_d, out_hit_q, out_hit_d, out_ev_q, out_ev_d;
  logic signed [VALUE_W-1:0] out_val_q, out_val_d;
  logic [KEY_W-1:0] out_evk_q, out_evk_d;

  // entry RAM and compare unit
  logic ram_we;
  logic [ROW_W-1:0] ram_rdata, ram_wdata;
  logic [KW-1:0] row_key;
  logic signed [VALUE_W-1:0] row_val, new_val;
  logic [IW-1:0] row_rank, new_rank;
  logic upd_phase, scan_strobe, row_is_tgt, row_age;

  scan_flags_t flags;
  logic [IW-1:0] match_idx, match_rank, lru_idx, free_idx;
  logic signed [VALUE_W-1:0] match_value;
  logic [KW-1:0] lru_key;

  logic [CW-1:0] eff_cap, occ_ext, cap_ext;
  logic hit_c, put_miss_c, use_lru_c;

  assign {row_key, row_val, row_rank} = ram_rdata;

  assign upd_phase   = (state_q == ST_UPD) || (state_q == ST_UPD_END);
  assign scan_strobe = rvld_q && ((state_q == ST_SCAN) || (state_q == ST_SCAN_END));
  assign row_is_tgt  = (ridx_q == tgt_q);
  // an insertion ages every other valid entry, a hit only the more recent ones
  assign row_age     = ins_q || (row_rank < rank_q);
  assign ram_we      = rvld_q && upd_phase && (valid_q[ridx_q] || row_is_tgt);
  assign new_val     = (op_q == OP_PUT) ? val_q : row_val;
  assign new_rank    = row_age ? IW'(row_rank + 1'b1) : row_rank;
  assign ram_wdata   = row_is_tgt ? {key_q, new_val, {IW{1'b0}}}
                                  : {row_key, row_val, new_rank};

  lkv_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ridx_q),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  lkv_scan #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       ((state_q == ST_IDLE) && req_i.valid),
    .strobe_i      (scan_strobe),
    .idx_i         (ridx_q),
    .entry_valid_i (valid_q[ridx_q]),
    .entry_key_i   (row_key),
    .entry_rank_i  (row_rank),
    .entry_value_i (row_val),
    .lookup_key_i  (key_q),
    .flags_o       (flags),
    .match_idx_o   (match_idx),
    .match_rank_o  (match_rank),
    .match_value_o (match_value),
    .lru_idx_o     (lru_idx),
    .lru_key_o     (lru_key),
    .free_idx_o    (free_idx)
  );

  // capacity 0 acts as 1, above ENTRIES as ENTRIES
  assign cap_ext = CW'(cap_q);
  assign occ_ext = CW'(occ_q);
  assign eff_cap = (cap_q == '0) ? CW'(1)
                 : ((cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext);

  assign hit_c      = flags.match;
  assign put_miss_c = (op_q == OP_PUT) && !flags.match;
  assign use_lru_c  = ((occ_ext >= eff_cap) && flags.lru) || !flags.free;

  assign req_i.ready       = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.read_value  = out_val_q;
  assign rsp_o.evicted     = out_ev_q;
  assign rsp_o.evicted_key = out_evk_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ridx_d      = cnt_q;
    rvld_d      = 1'b0;
    tgt_d       = tgt_q;
    rank_d      = rank_q;
    ins_d       = ins_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    cap_d       = cfg_i.valid ? cfg_i.capacity_in_use : cap_q;
    valid_d     = valid_q;
    occ_d       = occ_q;
    res_hit_d   = res_hit_q;
    res_val_d   = res_val_q;
    res_ev_d    = res_ev_q;
    res_evk_d   = res_evk_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_hit_d   = out_hit_q;
    out_val_d   = out_val_q;
    out_ev_d    = out_ev_q;
    out_evk_d   = out_evk_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          op_d    = opcode_e'(req_i.opcode);
          key_d   = req_i.key[KW-1:0];
          val_d   = req_i.put_value;
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN, ST_UPD: begin
        rvld_d = 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = (state_q == ST_SCAN) ? ST_SCAN_END : ST_UPD_END;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cnt_d     = '0;
        rank_d    = match_rank;
        ins_d     = put_miss_c;
        res_hit_d = hit_c;
        res_ev_d  = put_miss_c && use_lru_c;
        res_evk_d = (put_miss_c && use_lru_c) ? KEY_W'(lru_key) : '0;
        if (op_q == OP_GET) begin
          res_val_d = hit_c ? match_value : MISS_VALUE;
        end else begin
          res_val_d = '0;
        end
        if (hit_c) begin
          tgt_d = match_idx;
        end else begin
          tgt_d = use_lru_c ? lru_idx : free_idx;
        end
        if (put_miss_c) begin
          valid_d[tgt_d] = 1'b1;
          if (!use_lru_c) occ_d = occ_q + 1'b1;
        end
        state_d = (hit_c || put_miss_c) ? ST_UPD : ST_RESULT;
      end
      ST_UPD_END: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_hit_d   = res_hit_q;
          out_val_d   = res_val_q;
          out_ev_d    = res_ev_q;
          out_evk_d   = res_evk_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ridx_q      <= '0;
      rvld_q      <= 1'b0;
      tgt_q       <= '0;
      rank_q      <= '0;
      ins_q       <= 1'b0;
      op_q        <= OP_GET;
      key_q       <= '0;
      val_q       <= '0;
      cap_q       <= CAP_RESET;
      valid_q     <= '0;
      occ_q       <= '0;
      res_hit_q   <= 1'b0;
      res_val_q   <= '0;
      res_ev_q    <= 1'b0;
      res_evk_q   <= '0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_val_q   <= '0;
      out_ev_q    <= 1'b0;
      out_evk_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ridx_q      <= ridx_d;
      rvld_q      <= rvld_d;
      tgt_q       <= tgt_d;
      rank_q      <= rank_d;
      ins_q       <= ins_d;
      op_q        <= op_d;
      key_q       <= key_d;
      val_q       <= val_d;
      cap_q       <= cap_d;
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      res_hit_q   <= res_hit_d;
      res_val_q   <= res_val_d;
      res_ev_q    <= res_ev_d;
      res_evk_q   <= res_evk_d;
      out_valid_q <= out_valid_d;
      out_hit_q   <= out_hit_d;
      out_val_q   <= out_val_d;
      out_ev_q    <= out_ev_d;
      out_evk_q   <= out_evk_d;
    end
  end

  // occupancy tracks the number of valid entries
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy does not match valid bits");

  a_occ_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= ENTRIES)
    else $error("occupancy above entry count");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> state_q == ST_SCAN)
    else $error("request transfer did not start a lookup sweep");

  a_write_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> upd_phase && (ins_q || res_hit_q))
    else $error("entry write outside an update sweep");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && rsp_o.evicted))
    else $error("response flags both hit and eviction");

endmodule
